// ===== sv/mips_integer_execute_unit_top_macros.svh =====
// Assertion macros shared by the execute unit modules.
`ifndef MIPS_INTEGER_EXECUTE_UNIT_TOP_MACROS_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_TOP_MACROS_SVH
`define MIEU_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define MIEU_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`endif

// ===== sv/mieu_pkg.sv =====
// ----------------------------------------------------------------------------
// mieu_pkg
// Types and codes shared by the integer execute unit.
// ----------------------------------------------------------------------------
package mieu_pkg;
    localparam int unsigned XLEN = 32;
    localparam int unsigned CMD_W = 4;
    localparam int unsigned RIDX_W = 5;
    localparam int unsigned CNT_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD  = 4'd0,
        CMD_ADDI = 4'd1,
        CMD_AND  = 4'd2,
        CMD_BEQ  = 4'd3,
        CMD_BGTZ = 4'd4,
        CMD_BLEZ = 4'd5,
        CMD_BNE  = 4'd6,
        CMD_DIV  = 4'd7,
        CMD_J    = 4'd8
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [XLEN-1:0]  instr_word;
    } req_t;

    typedef struct packed {
        logic              reg_written;
        logic [RIDX_W-1:0] reg_index;
        logic [XLEN-1:0]   reg_value;
        logic [XLEN-1:0]   hi_value;
        logic [XLEN-1:0]   lo_value;
        logic [XLEN-1:0]   pc_value;
        logic              branch_taken;
        logic              divide_by_zero;
    } rsp_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

// ===== sv/mieu_if.sv =====
// ----------------------------------------------------------------------------
// mieu_req_if / mieu_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface mieu_req_if;
    import mieu_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mieu_rsp_if;
    import mieu_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/mips_integer_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// mips_integer_execute_unit_top
// Executes one instruction of the subset per request.
// ----------------------------------------------------------------------------
// Every request goes from acceptance to result through a read of the register
// file memory, a start of the bit-serial unit, a run state in which that unit
// handles add, and, compare and the divide one bit per cycle, and a writeback
// state. A new request is accepted once the unit is idle and the result
// register is free.
`include "mips_integer_execute_unit_top_macros.svh"
module mips_integer_execute_unit_top #(
    parameter int unsigned REG_COUNT = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    mieu_req_if.sink  req,
    mieu_rsp_if.source rsp
);
    import mieu_pkg::*;

    localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_GO   = 5'b00100,
        ST_RUN  = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    state_t           st_reg, st_next;
    logic [31:0]      gpr [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [31:0]      a_reg, b_reg, rda, rdb;
    logic [3:0]       cmd_reg;
    logic [31:0]      w_reg;
    logic [31:0]      hi_reg, lo_reg, pc_reg;
    logic             ov_reg;
    rsp_t             out_reg;
    logic             accept;
    logic [4:0]       rs, rt, rd;
    logic [31:0]      imm, opb, a_op, b_op;
    logic             a_ok, b_ok;
    logic             alu_done;
    logic [31:0]      sum, conj, quot, rem;
    logic             equal, a_zero;
    logic             wr, taken, dz, wok;
    logic [4:0]       widx;
    logic [31:0]      wval, pc_n, hi_n, lo_n;

    assign rs = w_reg[25:21];
    assign rt = w_reg[20:16];
    assign rd = w_reg[15:11];
    assign imm = {{16{w_reg[15]}}, w_reg[15:0]};
    assign accept = req.valid && req.ready;
    assign req.ready = (st_reg == ST_IDLE) && !ov_reg;

    assign a_ok = (rs != 5'd0) && (32'(rs) < REG_COUNT) && vld_reg[rs[AW-1:0]];
    assign b_ok = (rt != 5'd0) && (32'(rt) < REG_COUNT) && vld_reg[rt[AW-1:0]];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rda <= gpr[req.data.instr_word[21 +: AW]];
            rdb <= gpr[req.data.instr_word[16 +: AW]];
        end
        if (st_reg == ST_WB && wok)
        begin
            gpr[widx[AW-1:0]] <= wval;
        end
    end

    assign a_op = a_reg;
    assign opb = (cmd_reg == CMD_ADDI) ? imm : b_reg;
    assign b_op = opb;

    mieu_serial_alu u_alu (
        .clk(clk), .rst_n(rst_n),
        .start(st_reg == ST_GO),
        .is_div(cmd_reg == CMD_DIV),
        .op_a(a_op), .op_b(b_op),
        .done(alu_done),
        .sum(sum), .conj(conj), .equal(equal), .a_zero(a_zero),
        .quot(quot), .rem(rem)
    );

    logic [31:0] sum_reg, conj_reg, quot_reg, rem_reg;
    logic        eq_reg, az_reg;

    always_ff @(posedge clk)
    begin
        if (alu_done)
        begin
            sum_reg <= sum;
            conj_reg <= conj;
            quot_reg <= quot;
            rem_reg <= rem;
            eq_reg <= equal;
            az_reg <= a_zero;
        end
    end

    always_comb
    begin
        wr = 1'b0;
        taken = 1'b0;
        dz = 1'b0;
        widx = '0;
        wval = '0;
        hi_n = hi_reg;
        lo_n = lo_reg;
        pc_n = pc_reg;
        unique case (cmd_reg)
            CMD_ADD:  begin widx = rd; wval = sum_reg; wr = 1'b1; end
            CMD_ADDI: begin widx = rt; wval = sum_reg; wr = 1'b1; end
            CMD_AND:  begin widx = rd; wval = conj_reg; wr = 1'b1; end
            CMD_BEQ:  taken = eq_reg;
            CMD_BGTZ: taken = !a_reg[31] && !az_reg;
            CMD_BLEZ: taken = a_reg[31] || az_reg;
            CMD_BNE:  taken = !eq_reg;
            CMD_DIV:
            begin
                if (b_reg == 32'd0)
                begin
                    dz = 1'b1;
                end
                else
                begin
                    lo_n = quot_reg;
                    hi_n = rem_reg;
                end
            end
            CMD_J:
            begin
                pc_n = {6'd0, w_reg[25:0]};
                taken = 1'b1;
            end
            default: ;
        endcase
        if (taken && cmd_reg != CMD_J)
        begin
            pc_n = pc_reg + imm;
        end
        wok = wr && (widx != 5'd0) && (32'(widx) < REG_COUNT);
        if (!wok)
        begin
            widx = '0;
            wval = '0;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE: if (accept) st_next = ST_RD;
            ST_RD:   st_next = ST_GO;
            ST_GO:   st_next = ST_RUN;
            ST_RUN:  if (alu_done) st_next = ST_WB;
            ST_WB:   st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            vld_reg <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
            pc_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_WB)
            begin
                hi_reg <= hi_n;
                lo_reg <= lo_n;
                pc_reg <= pc_n;
                ov_reg <= 1'b1;
                if (wok)
                begin
                    vld_reg[widx[AW-1:0]] <= 1'b1;
                end
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.data.command;
            w_reg <= req.data.instr_word;
        end
        if (st_reg == ST_RD)
        begin
            a_reg <= a_ok ? rda : 32'd0;
            b_reg <= b_ok ? rdb : 32'd0;
        end
        if (st_reg == ST_WB)
        begin
            out_reg.reg_written <= wok;
            out_reg.reg_index <= widx;
            out_reg.reg_value <= wval;
            out_reg.hi_value <= hi_n;
            out_reg.lo_value <= lo_n;
            out_reg.pc_value <= pc_n;
            out_reg.branch_taken <= taken;
            out_reg.divide_by_zero <= dz;
        end
    end

    assign rsp.valid = ov_reg;
    assign rsp.data = out_reg;

    `MIEU_ASSERT_IMPL(a_wb_valid, clk, rst_n, st_reg == ST_WB |=> rsp.valid)
    `MIEU_ASSERT_NEVER(a_ready_busy, clk, rst_n, req.ready && st_reg != ST_IDLE)
    `MIEU_ASSERT_IMPL(a_done_run, clk, rst_n, alu_done |-> st_reg == ST_RUN)
endmodule

// ===== sv/mieu_serial_alu.sv =====
// ----------------------------------------------------------------------------
// mieu_serial_alu
// Bit-serial unit: add, and, equality and zero tests, and a restoring
// signed divider, all one bit per cycle.
// ----------------------------------------------------------------------------
`include "mips_integer_execute_unit_top_macros.svh"
module mieu_serial_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  is_div,
    input  logic [31:0]           op_a,
    input  logic [31:0]           op_b,
    output logic                  done,
    output logic [31:0]           sum,
    output logic [31:0]           conj,
    output logic                  equal,
    output logic                  a_zero,
    output logic [31:0]           quot,
    output logic [31:0]           rem
);
    import mieu_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             div_reg, div_next;
    logic [31:0]      a_reg, a_next, b_reg, b_next;
    logic [31:0]      s_reg, s_next, c_reg, c_next;
    logic             cy_reg, cy_next, eq_reg, eq_next, az_reg, az_next;
    logic [32:0]      r_reg, r_next;
    logic [31:0]      q_reg, q_next;
    logic             qn_reg, qn_next, rn_reg, rn_next;
    logic [31:0]      ua, ub;
    logic [32:0]      rs, rd;
    logic             sb;
    logic [31:0]      qf, rf;

    assign ua = op_a[31] ? (~op_a + 32'd1) : op_a;
    assign ub = op_b[31] ? (~op_b + 32'd1) : op_b;
    assign rs = {r_reg[31:0], q_reg[31]};
    assign rd = rs - {1'b0, b_reg};
    assign sb = a_reg[0] ^ b_reg[0] ^ cy_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        div_next = div_reg;
        a_next = a_reg;
        b_next = b_reg;
        s_next = s_reg;
        c_next = c_reg;
        cy_next = cy_reg;
        eq_next = eq_reg;
        az_next = az_reg;
        r_next = r_reg;
        q_next = q_reg;
        qn_next = qn_reg;
        rn_next = rn_reg;
        done = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            div_next = is_div;
            a_next = op_a;
            b_next = is_div ? ub : op_b;
            q_next = ua;
            r_next = '0;
            cy_next = 1'b0;
            eq_next = 1'b1;
            az_next = 1'b1;
            qn_next = op_a[31] ^ op_b[31];
            rn_next = op_a[31];
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (rd[32])
                begin
                    r_next = rs;
                    q_next = {q_reg[30:0], 1'b0};
                end
                else
                begin
                    r_next = rd;
                    q_next = {q_reg[30:0], 1'b1};
                end
            end
            else
            begin
                s_next = {sb, s_reg[31:1]};
                c_next = {a_reg[0] & b_reg[0], c_reg[31:1]};
                cy_next = (a_reg[0] & b_reg[0]) | (cy_reg & (a_reg[0] ^ b_reg[0]));
                eq_next = eq_reg & (a_reg[0] == b_reg[0]);
                az_next = az_reg & ~a_reg[0];
                a_next = {1'b0, a_reg[31:1]};
                b_next = {1'b0, b_reg[31:1]};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(31))
            begin
                busy_next = 1'b0;
                done = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        a_reg <= a_next;
        b_reg <= b_next;
        s_reg <= s_next;
        c_reg <= c_next;
        cy_reg <= cy_next;
        eq_reg <= eq_next;
        az_reg <= az_next;
        r_reg <= r_next;
        q_reg <= q_next;
        qn_reg <= qn_next;
        rn_reg <= rn_next;
    end

    assign qf = q_next;
    assign rf = r_next[31:0];
    assign sum = s_next;
    assign conj = c_next;
    assign equal = eq_next;
    assign a_zero = az_next;
    assign quot = qn_reg ? (~qf + 32'd1) : qf;
    assign rem = rn_reg ? (~rf + 32'd1) : rf;

    `MIEU_ASSERT_NEVER(a_start_busy, clk, rst_n, start && busy_reg)
    `MIEU_ASSERT_IMPL(a_done_end, clk, rst_n, done |-> busy_reg && cnt_reg == CNT_W'(31))
    `MIEU_ASSERT_IMPL(a_start_busy_next, clk, rst_n, start |=> busy_reg)
endmodule
